// ----- src/m3i_pkg.sv -----
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared constants for the 3x3 fixed-point matrix inverse pipeline.
// ----------------------------------------------------------------------------
package m3i_pkg;

    // default entry format: signed Q16.16
    localparam int ENTRY_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // matrix entry count
    localparam int NUM_ENTRY = 9;

    // adjugate entry i = a[p] * a[q] - a[r] * a[s], row-major a index
    localparam int COF_IDX [0:8][0:3] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

endpackage

// ----- src/m3i_cofactor.sv -----
// ----------------------------------------------------------------------------
// m3i_cofactor
// Two pipeline stages: the eighteen entry products, then the nine adjugate
// entries (transposed cofactors), exact at 2W+1 bits.
// ----------------------------------------------------------------------------
module m3i_cofactor #(
    parameter int W = m3i_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                clk,
    input  logic [1:0]          ce,
    input  logic signed [W-1:0] a    [m3i_pkg::NUM_ENTRY],
    output logic signed [W-1:0] arow [3],
    output logic signed [2*W:0] cof  [m3i_pkg::NUM_ENTRY]
);

    logic signed [2*W-1:0] prod_reg  [2*m3i_pkg::NUM_ENTRY];
    logic signed [W-1:0]   arow0_reg [3];
    logic signed [W-1:0]   arow1_reg [3];
    logic signed [2*W:0]   cof_reg   [m3i_pkg::NUM_ENTRY];

    // stage 0: entry products
    always_ff @(posedge clk)
    begin
        if (ce[0])
        begin
            for (int i = 0; i < m3i_pkg::NUM_ENTRY; i++)
            begin
                prod_reg[2*i]   <= a[m3i_pkg::COF_IDX[i][0]] * a[m3i_pkg::COF_IDX[i][1]];
                prod_reg[2*i+1] <= a[m3i_pkg::COF_IDX[i][2]] * a[m3i_pkg::COF_IDX[i][3]];
            end
            for (int k = 0; k < 3; k++)
            begin
                arow0_reg[k] <= a[k];
            end
        end
    end

    // stage 1: product differences
    always_ff @(posedge clk)
    begin
        if (ce[1])
        begin
            for (int i = 0; i < m3i_pkg::NUM_ENTRY; i++)
            begin
                cof_reg[i] <= $signed({prod_reg[2*i][2*W-1], prod_reg[2*i]})
                            - $signed({prod_reg[2*i+1][2*W-1], prod_reg[2*i+1]});
            end
            for (int k = 0; k < 3; k++)
            begin
                arow1_reg[k] <= arow0_reg[k];
            end
        end
    end

    assign arow = arow1_reg;
    assign cof  = cof_reg;

endmodule

// ----- src/m3i_det.sv -----
// ----------------------------------------------------------------------------
// m3i_det
// Four pipeline stages: determinant by first-row expansion with split
// multiplies, then magnitudes and signs of determinant and adjugate entries.
// ----------------------------------------------------------------------------
module m3i_det #(
    parameter int W = m3i_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                clk,
    input  logic [3:0]          ce,
    input  logic signed [W-1:0] arow [3],
    input  logic signed [2*W:0] cof  [m3i_pkg::NUM_ENTRY],
    output logic [3*W+1:0]      absd,
    output logic                dneg,
    output logic                dzero,
    output logic [2*W-1:0]      cmag [m3i_pkg::NUM_ENTRY],
    output logic                cneg [m3i_pkg::NUM_ENTRY]
);

    localparam int DW = 3*W + 2;

    logic signed [2*W:0]   plo_reg  [3];
    logic signed [2*W:0]   phi_reg  [3];
    logic signed [DW-1:0]  term_reg [3];
    logic signed [DW-1:0]  det_reg;
    logic signed [2*W:0]   cof2_reg [m3i_pkg::NUM_ENTRY];
    logic signed [2*W:0]   cof3_reg [m3i_pkg::NUM_ENTRY];
    logic signed [2*W:0]   cof4_reg [m3i_pkg::NUM_ENTRY];
    logic [DW-1:0]         absd_reg;
    logic                  dneg_reg;
    logic                  dzero_reg;
    logic [2*W-1:0]        cmag_reg [m3i_pkg::NUM_ENTRY];
    logic                  cneg_reg [m3i_pkg::NUM_ENTRY];
    logic [2*W:0]          cneg_val [m3i_pkg::NUM_ENTRY];
    logic [DW-1:0]         dneg_val;

    // stage 2: low and high partial products of a0*c00, a1*c10, a2*c20
    always_ff @(posedge clk)
    begin
        if (ce[0])
        begin
            for (int k = 0; k < 3; k++)
            begin
                plo_reg[k] <= arow[k] * $signed({1'b0, cof[3*k][W-1:0]});
                phi_reg[k] <= arow[k] * $signed(cof[3*k][2*W:W]);
            end
            cof2_reg <= cof;
        end
    end

    // stage 3: recombine each product
    always_ff @(posedge clk)
    begin
        if (ce[1])
        begin
            for (int k = 0; k < 3; k++)
            begin
                term_reg[k] <= (DW'(phi_reg[k]) <<< W) + DW'(plo_reg[k]);
            end
            cof3_reg <= cof2_reg;
        end
    end

    // stage 4: determinant sum
    always_ff @(posedge clk)
    begin
        if (ce[2])
        begin
            det_reg  <= term_reg[0] + term_reg[1] + term_reg[2];
            cof4_reg <= cof3_reg;
        end
    end

    // stage 5: magnitudes and signs
    always_comb
    begin
        dneg_val = -det_reg;
        for (int i = 0; i < m3i_pkg::NUM_ENTRY; i++)
        begin
            cneg_val[i] = -cof4_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce[3])
        begin
            dneg_reg  <= det_reg[DW-1];
            dzero_reg <= (det_reg == '0);
            absd_reg  <= det_reg[DW-1] ? dneg_val : det_reg;
            for (int i = 0; i < m3i_pkg::NUM_ENTRY; i++)
            begin
                cneg_reg[i] <= cof4_reg[i][2*W];
                cmag_reg[i] <= cof4_reg[i][2*W] ? cneg_val[i][2*W-1:0]
                                                : cof4_reg[i][2*W-1:0];
            end
        end
    end

    assign absd  = absd_reg;
    assign dneg  = dneg_reg;
    assign dzero = dzero_reg;
    assign cmag  = cmag_reg;
    assign cneg  = cneg_reg;

endmodule

// ----- src/m3i_divider.sv -----
// ----------------------------------------------------------------------------
// m3i_divider
// Pipelined restoring divider for one result entry: numerator setup, range
// check, then one quotient bit per stage, rounded to nearest.
// ----------------------------------------------------------------------------
module m3i_divider #(
    parameter int W = m3i_pkg::ENTRY_WIDTH_DEF,
    parameter int F = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic           clk,
    input  logic [W+1:0]   ce,
    input  logic [2*W-1:0] cmag,
    input  logic           cneg,
    input  logic [3*W+1:0] absd,
    input  logic           dneg,
    output logic [W-1:0]   q,
    output logic           ovf,
    output logic           neg
);

    localparam int RW = (2*W + 2*F + 2 > 4*W + 2) ? 2*W + 2*F + 2 : 4*W + 2;

    logic [RW-1:0] num_reg;
    logic [RW-1:0] den6_reg;
    logic          neg6_reg;
    logic [RW-1:0] rem_reg [0:W-1];
    logic [RW-1:0] den_reg [0:W-1];
    logic [W-1:0]  q_reg   [0:W];
    logic          ovf_reg [0:W];
    logic          neg_reg [0:W];

    // numerator |c| * 2^(2F+1) + |d| over denominator 2|d|
    always_ff @(posedge clk)
    begin
        if (ce[0])
        begin
            num_reg  <= (RW'(cmag) << (2*F + 1)) + RW'(absd);
            den6_reg <= RW'(absd) << 1;
            neg6_reg <= cneg ^ dneg;
        end
    end

    // quotient of 2^W or more saturates
    always_ff @(posedge clk)
    begin
        if (ce[1])
        begin
            rem_reg[0] <= num_reg;
            den_reg[0] <= den6_reg;
            ovf_reg[0] <= (num_reg >= (den6_reg << W));
            neg_reg[0] <= neg6_reg;
            q_reg[0]   <= '0;
        end
    end

    // one quotient bit per stage, msb first
    for (genvar j = 0; j < W; j++)
    begin : g_step
        logic [RW-1:0] shifted;
        logic          ge;

        assign shifted = den_reg[j] << (W - 1 - j);
        assign ge      = (rem_reg[j] >= shifted);

        always_ff @(posedge clk)
        begin
            if (ce[2+j])
            begin
                q_reg[j+1]   <= q_reg[j] | (W'(ge) << (W - 1 - j));
                ovf_reg[j+1] <= ovf_reg[j];
                neg_reg[j+1] <= neg_reg[j];
            end
        end

        if (j < W - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (ce[2+j])
                begin
                    rem_reg[j+1] <= ge ? rem_reg[j] - shifted : rem_reg[j];
                    den_reg[j+1] <= den_reg[j];
                end
            end
        end
    end

    assign q   = q_reg[W];
    assign ovf = ovf_reg[W];
    assign neg = neg_reg[W];

endmodule

// ----- src/matrix3_inverse.sv -----
// ----------------------------------------------------------------------------
// matrix3_inverse
// Inverse of a 3x3 signed fixed-point matrix via the adjugate, pipelined.
// ----------------------------------------------------------------------------
// pipeline: cofactor, determinant and divider stages, then the output register
// throughput: one request per cycle unless stalled; the one-bit-per-stage divider sets depth
// stalls fill empty stages first, so requests are taken until all are full
// reset: rst_n clears all stage valid bits asynchronously; data is not reset
module matrix3_inverse #(
    parameter int FRAC_BITS   = m3i_pkg::FRAC_BITS_DEF,
    parameter int ENTRY_WIDTH = m3i_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [ENTRY_WIDTH-1:0] a00,
    input  logic signed [ENTRY_WIDTH-1:0] a01,
    input  logic signed [ENTRY_WIDTH-1:0] a02,
    input  logic signed [ENTRY_WIDTH-1:0] a10,
    input  logic signed [ENTRY_WIDTH-1:0] a11,
    input  logic signed [ENTRY_WIDTH-1:0] a12,
    input  logic signed [ENTRY_WIDTH-1:0] a20,
    input  logic signed [ENTRY_WIDTH-1:0] a21,
    input  logic signed [ENTRY_WIDTH-1:0] a22,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [ENTRY_WIDTH-1:0] b00,
    output logic signed [ENTRY_WIDTH-1:0] b01,
    output logic signed [ENTRY_WIDTH-1:0] b02,
    output logic signed [ENTRY_WIDTH-1:0] b10,
    output logic signed [ENTRY_WIDTH-1:0] b11,
    output logic signed [ENTRY_WIDTH-1:0] b12,
    output logic signed [ENTRY_WIDTH-1:0] b20,
    output logic signed [ENTRY_WIDTH-1:0] b21,
    output logic signed [ENTRY_WIDTH-1:0] b22,
    output logic                          singular,
    output logic                          saturated
);

    localparam int W  = ENTRY_WIDTH;
    localparam int NE = m3i_pkg::NUM_ENTRY;
    localparam int NS = W + 9;

    logic [NS-1:0]         valid_reg;
    logic [NS-1:0]         ce;
    logic signed [W-1:0]   a_in [NE];
    logic signed [W-1:0]   arow [3];
    logic signed [2*W:0]   cof  [NE];
    logic [3*W+1:0]        absd;
    logic                  dneg;
    logic                  dzero;
    logic [2*W-1:0]        cmag [NE];
    logic                  cneg [NE];
    logic [W-1:0]          dq   [NE];
    logic                  dovf [NE];
    logic                  dsgn [NE];
    logic                  sing_reg [0:W+1];
    logic [W-1:0]          res_next [NE];
    logic [NE-1:0]         over_next;
    logic [W-1:0]          b_reg [NE];
    logic                  singular_reg;
    logic                  saturated_reg;

    // stage advance: a stage loads when it is empty or the next one loads
    always_comb
    begin
        ce[NS-1] = !valid_reg[NS-1] || !out_stall;
        for (int k = NS - 2; k >= 0; k--)
        begin
            ce[k] = !valid_reg[k] || ce[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ce[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (ce[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign in_stall  = !ce[0];
    assign out_valid = valid_reg[NS-1];

    assign a_in = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};

    // adjugate
    m3i_cofactor #(
        .W (W)
    ) u_cofactor (
        .clk  (clk),
        .ce   (ce[1:0]),
        .a    (a_in),
        .arow (arow),
        .cof  (cof)
    );

    // determinant and magnitudes
    m3i_det #(
        .W (W)
    ) u_det (
        .clk   (clk),
        .ce    (ce[5:2]),
        .arow  (arow),
        .cof   (cof),
        .absd  (absd),
        .dneg  (dneg),
        .dzero (dzero),
        .cmag  (cmag),
        .cneg  (cneg)
    );

    // one divider per result entry
    for (genvar i = 0; i < NE; i++)
    begin : g_div
        m3i_divider #(
            .W (W),
            .F (FRAC_BITS)
        ) u_divider (
            .clk  (clk),
            .ce   (ce[W+7:6]),
            .cmag (cmag[i]),
            .cneg (cneg[i]),
            .absd (absd),
            .dneg (dneg),
            .q    (dq[i]),
            .ovf  (dovf[i]),
            .neg  (dsgn[i])
        );
    end

    // singular flag rides alongside the divider stages
    always_ff @(posedge clk)
    begin
        if (ce[6])
        begin
            sing_reg[0] <= dzero;
        end
        for (int k = 1; k < W + 2; k++)
        begin
            if (ce[6+k])
            begin
                sing_reg[k] <= sing_reg[k-1];
            end
        end
    end

    // saturate, apply sign
    always_comb
    begin
        logic [W-1:0] lim;
        logic [W-1:0] mag;
        for (int i = 0; i < NE; i++)
        begin
            lim          = dsgn[i] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            over_next[i] = dovf[i] || (dq[i] > lim);
            mag          = over_next[i] ? lim : dq[i];
            res_next[i]  = dsgn[i] ? -mag : mag;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (ce[NS-1])
        begin
            for (int i = 0; i < NE; i++)
            begin
                b_reg[i] <= sing_reg[W+1] ? '0 : res_next[i];
            end
            singular_reg  <= sing_reg[W+1];
            saturated_reg <= !sing_reg[W+1] && (|over_next);
        end
    end

    assign b00       = $signed(b_reg[0]);
    assign b01       = $signed(b_reg[1]);
    assign b02       = $signed(b_reg[2]);
    assign b10       = $signed(b_reg[3]);
    assign b11       = $signed(b_reg[4]);
    assign b12       = $signed(b_reg[5]);
    assign b20       = $signed(b_reg[6]);
    assign b21       = $signed(b_reg[7]);
    assign b22       = $signed(b_reg[8]);
    assign singular  = singular_reg;
    assign saturated = saturated_reg;

endmodule

// ----- src/m3i_checker.sv -----
// ----------------------------------------------------------------------------
// m3i_checker
// Port-level assertions for matrix3_inverse, bound to the top level.
// ----------------------------------------------------------------------------
module m3i_checker #(
    parameter int ENTRY_WIDTH = m3i_pkg::ENTRY_WIDTH_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [ENTRY_WIDTH-1:0] b00,
    input logic signed [ENTRY_WIDTH-1:0] b11,
    input logic signed [ENTRY_WIDTH-1:0] b22,
    input logic                          singular,
    input logic                          saturated
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(b00) && $stable(b11)
            && $stable(b22) && $stable(singular) && $stable(saturated))
        else $error("stalled result changed");

    // singular results have zero b00, b11 and b22 and are never clipped
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> b00 == '0 && b11 == '0 && b22 == '0 && !saturated)
        else $error("singular result not cleared");

    // request side only stalls when the result side is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("request stalled with result side free");

    // an empty output stage keeps the request side from stalling
    a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("request stalled with empty output");

endmodule

bind matrix3_inverse m3i_checker #(.ENTRY_WIDTH(ENTRY_WIDTH)) u_m3i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .b00       (b00),
    .b11       (b11),
    .b22       (b22),
    .singular  (singular),
    .saturated (saturated)
);

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for matrix3_inverse: random and corner-case matrices
// go in, an exact big-integer predictor forms the expected inverse, and a
// scoreboard compares every result field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    localparam int W    = m3i_pkg::ENTRY_WIDTH_DEF;
    localparam int FB   = m3i_pkg::FRAC_BITS_DEF;
    localparam int BIG  = 256;
    localparam int NRAND = 1000;
    localparam longint LIMIT = 400000;

    typedef logic signed [W-1:0] entry_t;
    typedef logic signed [BIG-1:0] big_t;

    typedef struct {
        entry_t b [9];
        logic   sing;
        logic   sat;
    } inverse_t;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_stall;
    entry_t a [9];
    logic   out_valid;
    logic   out_stall;
    entry_t b [9];
    logic   singular;
    logic   saturated;

    int     errors = 0;
    longint cycles = 0;
    bit     hold_long = 0;
    bit     sending_done = 0;

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    // exact inverse: rounded quotient cofactor * 2^(2*FB) / det, ties away from zero
    function automatic inverse_t invert(input entry_t m [9]);
        inverse_t r;
        big_t e [9];
        big_t cof [9];
        big_t det, absd, num, q, lim;
        bit neg;
        for (int i = 0; i < 9; i++)
            e[i] = m[i];
        for (int i = 0; i < 9; i++)
            cof[i] = e[m3i_pkg::COF_IDX[i][0]] * e[m3i_pkg::COF_IDX[i][1]]
                   - e[m3i_pkg::COF_IDX[i][2]] * e[m3i_pkg::COF_IDX[i][3]];
        det = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
        r.sat = 0;
        r.sing = (det == 0);
        if (r.sing)
        begin
            for (int i = 0; i < 9; i++)
                r.b[i] = '0;
            return r;
        end
        absd = det < 0 ? -det : det;
        for (int i = 0; i < 9; i++)
        begin
            neg = (cof[i] < 0) != (det < 0);
            num = cof[i] < 0 ? -cof[i] : cof[i];
            num = (num <<< (2 * FB + 1)) + absd;
            q = num / (absd <<< 1);
            lim = (big_t'(1) <<< (W - 1)) - (neg ? 0 : 1);
            if (q > lim)
            begin
                q = lim;
                r.sat = 1;
            end
            r.b[i] = neg ? entry_t'(-q) : entry_t'(q);
        end
        return r;
    endfunction

    class inverse_board;
        inverse_t pending [$];

        function void note_request(input entry_t m [9]);
            pending.push_back(invert(m));
        endfunction

        task check_result(input entry_t got [9], input logic sing, input logic sat);
            inverse_t x;
            if (pending.size() == 0)
            begin
                report("result with nothing pending");
                return;
            end
            x = pending.pop_front();
            for (int i = 0; i < 9; i++)
                if (got[i] !== x.b[i])
                    report($sformatf("b%0d%0d got %h want %h", i / 3, i % 3, got[i], x.b[i]));
            if (sing !== x.sing)
                report($sformatf("singular got %b want %b", sing, x.sing));
            if (sat !== x.sat)
                report($sformatf("saturated got %b want %b", sat, x.sat));
        endtask
    endclass

    inverse_board board = new();

    matrix3_inverse dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .a00(a[0]), .a01(a[1]), .a02(a[2]), .a10(a[3]), .a11(a[4]),
        .a12(a[5]), .a20(a[6]), .a21(a[7]), .a22(a[8]),
        .out_valid(out_valid), .out_stall(out_stall),
        .b00(b[0]), .b01(b[1]), .b02(b[2]), .b10(b[3]), .b11(b[4]),
        .b12(b[5]), .b20(b[6]), .b21(b[7]), .b22(b[8]),
        .singular(singular), .saturated(saturated)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // offer one request and hold it until taken
    task automatic send_matrix(input entry_t m [9]);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        for (int i = 0; i < 9; i++)
            a[i] <= m[i];
        do
            @(posedge clk);
        while (in_stall);
        board.note_request(m);
    endtask

    function automatic entry_t rand_entry(input int kind);
        case (kind)
            0: return entry_t'($urandom);
            1: return entry_t'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
            2: return entry_t'($signed($urandom_range(0, 512)) - 256);
            default:
            begin
                case ($urandom_range(0, 5))
                    0: return {1'b1, {(W - 1){1'b0}}};
                    1: return {1'b0, {(W - 1){1'b1}}};
                    2: return '0;
                    3: return entry_t'(1 << FB);
                    4: return '1;
                    default: return entry_t'(-(1 << FB));
                endcase
            end
        endcase
    endfunction

    function automatic void fill_diag(output entry_t m [9], input entry_t d0,
                                      input entry_t d1, input entry_t d2);
        for (int i = 0; i < 9; i++)
            m[i] = '0;
        m[0] = d0;
        m[4] = d1;
        m[8] = d2;
    endfunction

    // stimulus
    initial
    begin
        entry_t m [9];
        int kind;
        in_valid = 0;
        for (int i = 0; i < 9; i++)
            a[i] = '0;
        @(posedge clk iff rst_n);
        // identity, scaled and tiny diagonals, extremes, singular cases
        fill_diag(m, 1 << FB, 1 << FB, 1 << FB);
        send_matrix(m);
        fill_diag(m, 2 << FB, -(4 << FB), 1 << (FB - 1));
        send_matrix(m);
        fill_diag(m, 1, 1, 1);
        send_matrix(m);
        fill_diag(m, {1'b1, {(W - 1){1'b0}}}, {1'b0, {(W - 1){1'b1}}}, '1);
        send_matrix(m);
        fill_diag(m, 0, 1 << FB, 1 << FB);
        send_matrix(m);
        for (int i = 0; i < 9; i++)
            m[i] = '0;
        send_matrix(m);
        for (int i = 0; i < 9; i++)
            m[i] = {1'b1, {(W - 1){1'b0}}};
        send_matrix(m);
        for (int i = 0; i < 9; i++)
            m[i] = {1'b0, {(W - 1){1'b1}}};
        send_matrix(m);
        for (int i = 0; i < 9; i++)
            m[i] = entry_t'(i + 1) << FB;
        send_matrix(m);
        // determinant of -105 ulp cubed: large results that stay in range
        fill_diag(m, 3, -5, 7);
        m[1] = 1;
        send_matrix(m);
        // exact power-of-two diagonal, then matrices of corner-value entries
        fill_diag(m, 2 << FB, 8 << FB, -(2 << FB));
        send_matrix(m);
        for (int j = 0; j < 8; j++)
        begin
            for (int i = 0; i < 9; i++)
                m[i] = rand_entry(3);
            send_matrix(m);
        end

        for (int n = 0; n < NRAND; n++)
        begin
            // receiver holds off once while we keep offering
            if (n == 300)
                hold_long = 1;
            // drain once before continuing
            if (n == 600)
            begin
                in_valid <= 0;
                wait (board.pending.size() == 0);
                @(posedge clk);
            end
            kind = $urandom_range(0, 9);
            for (int i = 0; i < 9; i++)
                m[i] = rand_entry(kind < 3 ? 0 : kind < 7 ? 1 : kind < 9 ? 2 : 3);
            // occasional rank-deficient matrix: copy one row
            if ($urandom_range(0, 7) == 0)
                for (int c = 0; c < 3; c++)
                    m[6 + c] = m[c];
            send_matrix(m);
        end
        in_valid <= 0;
        sending_done = 1;
    end

    // receiver stall pattern
    initial
    begin
        int gap;
        bit held;
        held = 0;
        out_stall = 0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_long && !held)
            begin
                held = 1;
                out_stall <= 1;
                repeat (150) @(posedge clk);
            end
            gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                out_stall <= 1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // result check
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(b, singular, saturated);
    end

    // end of run
    initial
    begin
        wait (sending_done);
        wait (board.pending.size() == 0);
        repeat (2 * W + 40) @(posedge clk);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule

// ----- files.f -----
src/m3i_pkg.sv
src/m3i_cofactor.sv
src/m3i_det.sv
src/m3i_divider.sv
src/matrix3_inverse.sv
src/m3i_checker.sv
sim/testbench.sv
